// ===== hdl/gamepad_poll_to_hid_report_macros.svh =====
// Assertion macros used by the checker file.
`ifndef GAMEPAD_POLL_TO_HID_REPORT_MACROS_SVH
`define GAMEPAD_POLL_TO_HID_REPORT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define GPHID_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gphid check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define GPHID_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gphid check failed");

`endif

// ===== hdl/gphid_pkg.sv =====
package gphid_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] MODE_ID_DIGITAL  = 8'h41;
  localparam logic [7:0] MODE_ID_ANALOG_A = 8'h79;
  localparam logic [7:0] MODE_ID_ANALOG_B = 8'h73;
  localparam logic [7:0] MODE_ID_NONE     = 8'hFF;

  localparam logic [1:0] CLS_DIGITAL = 2'd0;
  localparam logic [1:0] CLS_ANALOG  = 2'd1;
  localparam logic [1:0] CLS_NONE    = 2'd2;
  localparam logic [1:0] CLS_OTHER   = 2'd3;

  localparam logic [7:0] KIND_DIGITAL   = 8'd1;
  localparam logic [7:0] KIND_RESET     = 8'd3;
  localparam logic [7:0] KIND_UNPLUGGED = 8'd4;

  localparam logic [4:0] LIMIT_RESET    = 5'd20;
  localparam logic [4:0] SLOT_ONE_RESET = 5'd16;
  localparam logic [4:0] SLOT_TWO_RESET = 5'd15;
  localparam logic [4:0] SLOT_BASE      = 5'd5;

  localparam logic [7:0] AXIS_CENTER = 8'h80;
  localparam logic [7:0] AXIS_LOW    = 8'h00;
  localparam logic [7:0] AXIS_HIGH   = 8'hFF;
  localparam logic [7:0] START_FLAG  = 8'h20;

  localparam int HELD_COUNT = 16;

  typedef struct packed {
    logic         op;
    logic [1:0]   cls;
    logic [7:0]   b1;
    logic [7:0]   b2_dig;
    logic [7:0]   b2_ana;
    logic [7:0]   lx_dig;
    logic [7:0]   ly_dig;
    logic         combo_one;
    logic         combo_two;
    logic         pick_ok;
    logic [4:0]   pick;
    logic [127:0] bytes;
    logic [7:0]   status;
  } entry_t;

endpackage

// ===== hdl/gphid_front.sv =====
module gphid_front (
  input  logic [159:0]      in_tdata,
  input  logic              in_tuser,
  output gphid_pkg::entry_t entry
);

  logic [7:0] mode_id;
  logic [7:0] n_low;
  logic [7:0] n_high;

  assign mode_id = in_tdata[7:0];
  assign n_low   = ~in_tdata[15:8];
  assign n_high  = ~in_tdata[23:16];

  always_comb begin
    entry = '0;
    entry.op = in_tuser;

    unique case (mode_id)
      gphid_pkg::MODE_ID_DIGITAL:  entry.cls = gphid_pkg::CLS_DIGITAL;
      gphid_pkg::MODE_ID_ANALOG_A: entry.cls = gphid_pkg::CLS_ANALOG;
      gphid_pkg::MODE_ID_ANALOG_B: entry.cls = gphid_pkg::CLS_ANALOG;
      gphid_pkg::MODE_ID_NONE:     entry.cls = gphid_pkg::CLS_NONE;
      default:                     entry.cls = gphid_pkg::CLS_OTHER;
    endcase

    entry.b1 = {n_high[1], n_high[3], n_low[3], n_low[0],
                n_high[5], n_high[4], n_high[6], n_high[7]};
    entry.b2_dig = {6'b0, n_high[0], n_high[2]};
    entry.b2_ana = {n_low[2], n_low[1], n_low[5], n_low[7],
                    n_low[6], n_low[4], n_high[0], n_high[2]};

    entry.ly_dig = n_low[6] ? gphid_pkg::AXIS_HIGH :
                   (n_low[4] ? gphid_pkg::AXIS_LOW : gphid_pkg::AXIS_CENTER);
    entry.lx_dig = n_low[5] ? gphid_pkg::AXIS_HIGH :
                   (n_low[7] ? gphid_pkg::AXIS_LOW : gphid_pkg::AXIS_CENTER);

    entry.combo_one = n_low[0] & n_low[1] & n_low[3];
    entry.combo_two = n_low[0] & n_low[2] & n_low[3];

    entry.pick_ok = 1'b1;
    if (n_high != 8'h00) begin
      unique case (n_high)
        8'h01:   entry.pick = 5'd19;
        8'h02:   entry.pick = 5'd20;
        8'h04:   entry.pick = 5'd17;
        8'h08:   entry.pick = 5'd18;
        8'h10:   entry.pick = 5'd13;
        8'h20:   entry.pick = 5'd14;
        8'h40:   entry.pick = 5'd15;
        8'h80:   entry.pick = 5'd16;
        default: entry.pick_ok = 1'b0;
      endcase
    end else begin
      unique case (n_low[7:4])
        4'h1:    entry.pick = 5'd11;
        4'h2:    entry.pick = 5'd9;
        4'h4:    entry.pick = 5'd12;
        4'h8:    entry.pick = 5'd10;
        default: entry.pick_ok = 1'b0;
      endcase
    end

    entry.bytes  = in_tdata[151:24];
    entry.status = in_tdata[159:152];
  end

endmodule

// ===== hdl/gphid_queue.sv =====
module gphid_queue #(
  parameter int DEPTH = gphid_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  gphid_pkg::entry_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output gphid_pkg::entry_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  gphid_pkg::entry_t slots_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              push;
  logic              pop;

  assign push_ready = (cnt_r != CNT_FULL);
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = slots_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hdl/gphid_back.sv =====
module gphid_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  gphid_pkg::entry_t q_data,
  input  logic              cfg_valid,
  input  logic [4:0]        cfg_data,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata,
  output logic              out_tuser
);

  logic [4:0]  limit_r;
  logic [7:0]  kind_r, kind_nxt;
  logic        sp_r, sp_nxt;
  logic [4:0]  tries_r, tries_nxt;
  logic [4:0]  slot1_r, slot1_nxt;
  logic [4:0]  slot2_r, slot2_nxt;
  logic [7:0]  hb_r [gphid_pkg::HELD_COUNT];
  logic [7:0]  hb_nxt [gphid_pkg::HELD_COUNT];
  logic [63:0] rep_r, rep_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_data_r;
  logic        out_user_r;

  logic        pop;
  logic        emit;
  logic        run;
  logic        under_lim;
  logic        sp_mid;
  logic        sp_after;
  logic        digital;
  logic [4:0]  s1_off;
  logic [4:0]  s2_off;
  logic [7:0]  lx, ly, p1, p2, b2;

  assign q_ready    = q_data.op || !out_valid_r || out_tready;
  assign pop        = q_valid && q_ready;
  assign emit       = pop && !q_data.op;
  assign under_lim  = (tries_r < limit_r);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    kind_nxt  = kind_r;
    sp_nxt    = sp_r;
    tries_nxt = tries_r;
    slot1_nxt = slot1_r;
    slot2_nxt = slot2_r;
    rep_nxt   = rep_r;
    hb_nxt    = hb_r;
    run       = 1'b0;
    sp_mid    = sp_r;
    sp_after  = sp_r;
    digital   = 1'b0;
    s1_off    = '0;
    s2_off    = '0;
    lx        = '0;
    ly        = '0;
    p1        = '0;
    p2        = '0;
    b2        = '0;

    if (pop) begin
      if (q_data.op) begin
        kind_nxt = ((q_data.status == gphid_pkg::MODE_ID_NONE) && under_lim) ?
                   gphid_pkg::KIND_UNPLUGGED : q_data.status;
      end else if (kind_r == gphid_pkg::KIND_UNPLUGGED) begin
        rep_nxt[55:48] = gphid_pkg::START_FLAG;
        sp_nxt = 1'b1;
        run    = 1'b1;
      end else begin
        unique case (q_data.cls)
          gphid_pkg::CLS_DIGITAL: begin
            kind_nxt  = gphid_pkg::KIND_DIGITAL;
            hb_nxt[0] = 8'd1;
            hb_nxt[1] = 8'd1;
          end
          gphid_pkg::CLS_ANALOG: begin
            sp_mid = sp_r | (kind_r == gphid_pkg::KIND_DIGITAL);
            for (int k = 0; k < gphid_pkg::HELD_COUNT; k++) begin
              hb_nxt[k] = q_data.bytes[8*k +: 8];
            end
          end
          gphid_pkg::CLS_NONE: begin
            if (under_lim) begin
              kind_nxt  = gphid_pkg::KIND_UNPLUGGED;
              tries_nxt = tries_r + 1'b1;
            end
          end
          default: begin
          end
        endcase

        if ((q_data.cls != gphid_pkg::CLS_NONE) && sp_mid) begin
          sp_after = 1'b0;
          run      = 1'b1;
        end else begin
          sp_after = sp_mid;
        end
        sp_nxt = sp_after;

        if (!sp_after && q_data.combo_one && q_data.pick_ok) begin
          slot1_nxt = q_data.pick;
        end
        if (!sp_after && q_data.combo_two && q_data.pick_ok) begin
          slot2_nxt = q_data.pick;
        end

        s1_off  = slot1_nxt - gphid_pkg::SLOT_BASE;
        s2_off  = slot2_nxt - gphid_pkg::SLOT_BASE;
        digital = (({1'b0, hb_nxt[0]} + {1'b0, hb_nxt[1]}) == 9'd2);

        if (digital) begin
          lx = q_data.lx_dig;
          ly = q_data.ly_dig;
          p2 = '0;
          p1 = '0;
          b2 = q_data.b2_dig;
        end else begin
          lx = hb_nxt[2];
          ly = hb_nxt[3];
          p2 = hb_nxt[s2_off[3:0]];
          p1 = hb_nxt[s1_off[3:0]];
          b2 = q_data.b2_ana;
        end
        rep_nxt = {b2, q_data.b1, p1, p2, hb_nxt[1], hb_nxt[0], ly, lx};
      end
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= gphid_pkg::LIMIT_RESET;
      kind_r      <= gphid_pkg::KIND_RESET;
      sp_r        <= 1'b1;
      tries_r     <= '0;
      slot1_r     <= gphid_pkg::SLOT_ONE_RESET;
      slot2_r     <= gphid_pkg::SLOT_TWO_RESET;
      rep_r       <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < gphid_pkg::HELD_COUNT; k++) begin
        hb_r[k] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        limit_r <= cfg_data;
      end
      kind_r      <= kind_nxt;
      sp_r        <= sp_nxt;
      tries_r     <= tries_nxt;
      slot1_r     <= slot1_nxt;
      slot2_r     <= slot2_nxt;
      rep_r       <= rep_nxt;
      hb_r        <= hb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= rep_nxt;
      out_user_r <= run;
    end
  end

endmodule

// ===== hdl/gamepad_poll_to_hid_report.sv =====
// Turns decoded game-pad poll frames into eight-byte reports.
// The input channel carries one poll frame or one start-up status reply per
// transfer, told apart by in_tuser. A poll frame yields one report on the
// output channel; a status reply only updates the controller kind.
// The configuration channel writes the unplug retry limit; the user must do so
// only while the block is idle, not enforced by the block. It never stalls.
// With the queue and the output register empty, an input transfer is written
// into a queue slot, then popped into the output register, raising out_tvalid.
// One item is taken per cycle while in_tready is high: the front end
// classifies in the transfer cycle, and the back end retires one queued item
// per cycle, limited only by its single output register.
// Reset empties the queue and the output register and resets all held state;
// the report, stick and pressure bytes start at zero and the limit at 20.
// When the receiver stalls, the report waits in the output register, the
// queue fills with up to two more items, and then in_tready drops.
module gamepad_poll_to_hid_report #(
  parameter int QUEUE_DEPTH = gphid_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // mode_id, buttons_low, buttons_high, right_x_in, right_y_in, left_x_in,
  // left_y_in, pressure_first, pressure_second, status_byte
  input  logic [159:0] in_tdata,
  // operation
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // left_x, left_y, right_x, right_y, pressure_two, pressure_one,
  // buttons_one, buttons_two
  output logic [63:0]  out_tdata,
  // run_startup
  output logic         out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [4:0]   cfg_data
);

  gphid_pkg::entry_t front_entry;
  gphid_pkg::entry_t q_data;
  logic              q_valid;
  logic              q_ready;

  assign cfg_ready = 1'b1;

  gphid_front u_front (
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .entry    (front_entry)
  );

  gphid_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (in_tready),
    .push_data  (front_entry),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  gphid_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_data     (q_data),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== hdl/gphid_chk.sv =====
`include "gamepad_poll_to_hid_report_macros.svh"

module gphid_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tuser
);

  `GPHID_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `GPHID_ASSERT_IMPL(a_out_idle_after_reset, $past(!rst_n), !out_tvalid)
  `GPHID_ASSERT_IMPL(a_full_means_stalled, !in_tready, out_tvalid)
  `GPHID_ASSERT_IMPL(a_poll_reaches_output, in_tvalid && in_tready && !in_tuser && !out_tvalid, 1'b1 ##2 out_tvalid)

endmodule

bind gamepad_poll_to_hid_report gphid_chk u_chk (.*);
